>>> rtl/core/up_down_pulse_counter_with_limits_core_defines.svh
// ----------------------------------------------------------------------------
// Up/down pulse counter: assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet in reset.
// ----------------------------------------------------------------------------
`ifndef UP_DOWN_PULSE_COUNTER_WITH_LIMITS_CORE_DEFINES_SVH
`define UP_DOWN_PULSE_COUNTER_WITH_LIMITS_CORE_DEFINES_SVH

// same-cycle implication
`define UDPC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UDPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/udpc_pkg.sv
// ----------------------------------------------------------------------------
// Up/down pulse counter package
// Widths, register indexes, reset values and item types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package udpc_pkg;

	localparam int VALUE_W = 32;
	localparam int CFG_IDX_W = 3;

	localparam logic [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
	localparam logic [VALUE_W-1:0] STEP_RST = VALUE_W'(256);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_VALUE      = 3'd0,
		CFG_STEP_SIZE        = 3'd1,
		CFG_HIGH_LIMIT       = 3'd2,
		CFG_LOW_LIMIT        = 3'd3,
		CFG_LOW_ALARM_LEVEL  = 3'd4,
		CFG_HIGH_ALARM_LEVEL = 3'd5,
		CFG_LOW_WARN_MARGIN  = 3'd6,
		CFG_HIGH_WARN_MARGIN = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic [VALUE_W-1:0] start_value;
		logic [VALUE_W-1:0] step_size;
		logic [VALUE_W-1:0] high_limit;
		logic [VALUE_W-1:0] low_limit;
		logic [VALUE_W-1:0] low_alarm_level;
		logic [VALUE_W-1:0] high_alarm_level;
		logic [VALUE_W-1:0] low_warn_margin;
		logic [VALUE_W-1:0] high_warn_margin;
	} cfg_t;

	typedef struct packed {
		logic enable;
		logic pulse;
		logic count_down;
		logic hold;
		logic load_start;
	} item_t;

	typedef struct packed {
		logic at_start;
		logic at_high_limit;
		logic at_low_limit;
		logic low_warning;
		logic low_alarm;
		logic high_warning;
		logic high_alarm;
	} flags_t;

	typedef struct packed {
		logic [VALUE_W-1:0] count;
		logic               enabled_out;
		flags_t             flags;
	} result_t;

endpackage

>>> rtl/core/up_down_pulse_counter_with_limits_core.sv
// ----------------------------------------------------------------------------
// Up/down pulse counter with limits: input item registered in item_s1, result in out_q.
// Throughput one item per cycle unless out_ready stalls it; the count update is a single add and clamp.
// Reset clears both stage valids, count, edge memory, flags; config to defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "up_down_pulse_counter_with_limits_core_defines.svh"

module up_down_pulse_counter_with_limits_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [udpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [udpc_pkg::VALUE_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          enable,
	input  logic                          pulse,
	input  logic                          count_down,
	input  logic                          hold,
	input  logic                          load_start,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [udpc_pkg::VALUE_W-1:0] count,
	output logic                          enabled_out,
	output logic                          at_start,
	output logic                          at_high_limit,
	output logic                          at_low_limit,
	output logic                          low_warning,
	output logic                          low_alarm,
	output logic                          high_warning,
	output logic                          high_alarm
);
	import udpc_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t result;
	result_t out_q;
	logic    out_valid_q;
	logic    advance;

	assign cfg_ready = 1'b1;

	udpc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= '{enable: enable, pulse: pulse, count_down: count_down,
				hold: hold, load_start: load_start};
		end
	end

	udpc_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign out_valid     = out_valid_q;
	assign count         = $signed(out_q.count);
	assign enabled_out   = out_q.enabled_out;
	assign at_start      = out_q.flags.at_start;
	assign at_high_limit = out_q.flags.at_high_limit;
	assign at_low_limit  = out_q.flags.at_low_limit;
	assign low_warning   = out_q.flags.low_warning;
	assign low_alarm     = out_q.flags.low_alarm;
	assign high_warning  = out_q.flags.high_warning;
	assign high_alarm    = out_q.flags.high_alarm;

	`UDPC_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_q, "item lost between stages")
	`UDPC_ASSERT_NOW(a_stall_only_when_full, !in_ready,
		valid_s1 && out_valid_q && !out_ready, "input stalled without a full pipe")
	`UDPC_ASSERT_NEXT(a_taken_clears_out, out_valid_q && out_ready && !advance,
		!out_valid_q, "result repeated after it was taken")

endmodule

>>> rtl/core/udpc_cfg.sv
// ----------------------------------------------------------------------------
// Up/down pulse counter configuration bank
// Eight value registers written through the configuration channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module udpc_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [udpc_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [udpc_pkg::VALUE_W-1:0]   wr_data,
	output udpc_pkg::cfg_t                 cfg
);
	import udpc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_value      <= '0;
			cfg_q.step_size        <= STEP_RST;
			cfg_q.high_limit       <= VAL_MAX;
			cfg_q.low_limit        <= VAL_MIN;
			cfg_q.low_alarm_level  <= VAL_MIN;
			cfg_q.high_alarm_level <= VAL_MAX;
			cfg_q.low_warn_margin  <= '0;
			cfg_q.high_warn_margin <= '0;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				CFG_START_VALUE:      cfg_q.start_value      <= wr_data;
				CFG_STEP_SIZE:        cfg_q.step_size        <= wr_data;
				CFG_HIGH_LIMIT:       cfg_q.high_limit       <= wr_data;
				CFG_LOW_LIMIT:        cfg_q.low_limit        <= wr_data;
				CFG_LOW_ALARM_LEVEL:  cfg_q.low_alarm_level  <= wr_data;
				CFG_HIGH_ALARM_LEVEL: cfg_q.high_alarm_level <= wr_data;
				CFG_LOW_WARN_MARGIN:  cfg_q.low_warn_margin  <= wr_data;
				CFG_HIGH_WARN_MARGIN: cfg_q.high_warn_margin <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/core/udpc_step.sv
// ----------------------------------------------------------------------------
// Up/down pulse counter update
// Count state, edge memory and flags; one add, clamp and band check per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module udpc_step (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  udpc_pkg::item_t   item,
	input  udpc_pkg::cfg_t    cfg,
	output udpc_pkg::result_t result
);
	import udpc_pkg::*;

	logic [VALUE_W-1:0] count_q;
	logic               pulse_prev_q;
	logic               started_q;
	flags_t             flags_q;

	logic [VALUE_W-1:0]        base;
	logic [VALUE_W-1:0]        count_en;
	logic [VALUE_W-1:0]        count_next;
	logic signed [VALUE_W:0]   base_x;
	logic signed [VALUE_W:0]   step_x;
	logic signed [VALUE_W:0]   start_x;
	logic signed [VALUE_W:0]   hl_x;
	logic signed [VALUE_W:0]   ll_x;
	logic signed [VALUE_W:0]   sum_x;
	logic signed [VALUE_W:0]   cnt_x;
	logic signed [VALUE_W:0]   low_thr_x;
	logic signed [VALUE_W:0]   high_thr_x;
	logic                      rise;
	flags_t                    flags_en;
	flags_t                    flags_next;

	function automatic logic signed [VALUE_W:0] sx(input logic [VALUE_W-1:0] v);
		return $signed({v[VALUE_W-1], v});
	endfunction

	always_comb begin
		base    = started_q ? count_q : cfg.start_value;
		base_x  = sx(base);
		step_x  = sx(cfg.step_size);
		start_x = sx(cfg.start_value);
		hl_x    = sx(cfg.high_limit);
		ll_x    = sx(cfg.low_limit);
		rise    = item.pulse && !pulse_prev_q && !item.hold;

		priority if (item.load_start) begin
			sum_x = start_x;
		end else if (rise) begin
			sum_x = item.count_down ? (base_x - step_x) : (base_x + step_x);
		end else begin
			sum_x = base_x;
		end

		flags_en = flags_q;
		flags_en.at_start = (sum_x == start_x);

		priority if (sum_x >= hl_x) begin
			count_en = cfg.high_limit;
			flags_en.at_high_limit = 1'b1;
		end else if (sum_x <= ll_x) begin
			count_en = cfg.low_limit;
			flags_en.at_high_limit = 1'b0;
			flags_en.at_low_limit  = 1'b1;
		end else begin
			count_en = sum_x[VALUE_W-1:0];
			flags_en.at_high_limit = 1'b0;
			flags_en.at_low_limit  = 1'b0;
		end

		cnt_x      = sx(count_en);
		low_thr_x  = sx(cfg.low_alarm_level) + sx(cfg.low_warn_margin);
		high_thr_x = sx(cfg.high_alarm_level) - sx(cfg.high_warn_margin);

		if (cnt_x < low_thr_x) begin
			flags_en.low_warning = 1'b1;
			flags_en.low_alarm   = $signed(count_en) < $signed(cfg.low_alarm_level);
		end else begin
			flags_en.low_warning = 1'b0;
			flags_en.low_alarm   = 1'b0;
			if (high_thr_x < cnt_x) begin
				flags_en.high_warning = 1'b1;
				flags_en.high_alarm   = $signed(count_en) > $signed(cfg.high_alarm_level);
			end else begin
				flags_en.high_warning = 1'b0;
				flags_en.high_alarm   = 1'b0;
			end
		end

		count_next = item.enable ? count_en : base;
		flags_next = item.enable ? flags_en : flags_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			pulse_prev_q <= 1'b0;
			started_q    <= 1'b0;
			flags_q      <= '0;
		end else if (advance) begin
			count_q      <= count_next;
			pulse_prev_q <= item.pulse;
			started_q    <= 1'b1;
			flags_q      <= flags_next;
		end
	end

	assign result.count       = count_next;
	assign result.enabled_out = item.enable;
	assign result.flags       = flags_next;

endmodule

>>> tb/udpc_tick_checker.sv
// ----------------------------------------------------------------------------
// Up/down pulse counter: tick checker
// Tracks register writes, predicts the count and flags for every accepted
// input item, and compares each accepted result field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module udpc_tick_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [udpc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [udpc_pkg::VALUE_W-1:0]        cfg_data,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic                                enable,
	input  logic                                pulse,
	input  logic                                count_down,
	input  logic                                hold,
	input  logic                                load_start,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic signed [udpc_pkg::VALUE_W-1:0] count,
	input  logic                                enabled_out,
	input  logic                                at_start,
	input  logic                                at_high_limit,
	input  logic                                at_low_limit,
	input  logic                                low_warning,
	input  logic                                low_alarm,
	input  logic                                high_warning,
	input  logic                                high_alarm,
	output int                                  mismatches,
	output int                                  outstanding
);
	import udpc_pkg::*;

	longint  reg_val [8];
	longint  cur_count;
	bit      pulse_seen;
	bit      running;
	flags_t  cur_flags;
	result_t due_results [$];

	task automatic restore_defaults();
		reg_val[CFG_START_VALUE]      = 0;
		reg_val[CFG_STEP_SIZE]        = longint'($signed(STEP_RST));
		reg_val[CFG_HIGH_LIMIT]       = longint'($signed(VAL_MAX));
		reg_val[CFG_LOW_LIMIT]        = longint'($signed(VAL_MIN));
		reg_val[CFG_LOW_ALARM_LEVEL]  = longint'($signed(VAL_MIN));
		reg_val[CFG_HIGH_ALARM_LEVEL] = longint'($signed(VAL_MAX));
		reg_val[CFG_LOW_WARN_MARGIN]  = 0;
		reg_val[CFG_HIGH_WARN_MARGIN] = 0;
		cur_count  = 0;
		pulse_seen = 1'b0;
		running    = 1'b0;
		cur_flags  = '0;
	endtask

	task automatic advance_count(input item_t it, output result_t r);
		longint sum;
		if (!running)
			cur_count = reg_val[CFG_START_VALUE];
		if (it.enable) begin
			sum = cur_count;
			if (it.load_start)
				sum = reg_val[CFG_START_VALUE];
			else if (it.pulse && !pulse_seen && !it.hold)
				sum = it.count_down ? cur_count - reg_val[CFG_STEP_SIZE]
					: cur_count + reg_val[CFG_STEP_SIZE];
			cur_flags.at_start = (sum == reg_val[CFG_START_VALUE]);
			if (sum >= reg_val[CFG_HIGH_LIMIT]) begin
				cur_count = reg_val[CFG_HIGH_LIMIT];
				cur_flags.at_high_limit = 1'b1;
			end else begin
				cur_flags.at_high_limit = 1'b0;
				if (sum <= reg_val[CFG_LOW_LIMIT]) begin
					cur_count = reg_val[CFG_LOW_LIMIT];
					cur_flags.at_low_limit = 1'b1;
				end else begin
					cur_count = sum;
					cur_flags.at_low_limit = 1'b0;
				end
			end
			if (cur_count < reg_val[CFG_LOW_ALARM_LEVEL] + reg_val[CFG_LOW_WARN_MARGIN]) begin
				cur_flags.low_warning = 1'b1;
				cur_flags.low_alarm   = cur_count < reg_val[CFG_LOW_ALARM_LEVEL];
			end else begin
				cur_flags.low_warning = 1'b0;
				cur_flags.low_alarm   = 1'b0;
				if (reg_val[CFG_HIGH_ALARM_LEVEL] - reg_val[CFG_HIGH_WARN_MARGIN]
						< cur_count) begin
					cur_flags.high_warning = 1'b1;
					cur_flags.high_alarm   = cur_count > reg_val[CFG_HIGH_ALARM_LEVEL];
				end else begin
					cur_flags.high_warning = 1'b0;
					cur_flags.high_alarm   = 1'b0;
				end
			end
		end
		pulse_seen = it.pulse;
		running    = 1'b1;
		r.count       = cur_count[VALUE_W-1:0];
		r.enabled_out = it.enable;
		r.flags       = cur_flags;
	endtask

	task automatic compare_field(input string what, input longint want, input longint got);
		if (want != got) begin
			mismatches++;
			$display("%0t ns: %s expected %0d, got %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		result_t fresh;
		if (!arst_n) begin
			restore_defaults();
			due_results.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				reg_val[cfg_index] = longint'($signed(cfg_data));
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					mismatches++;
					$display("%0t ns: result with no item pending, count %0d", $time, count);
				end else begin
					want = due_results.pop_front();
					compare_field("count", longint'($signed(want.count)), longint'(count));
					compare_field("enabled_out", want.enabled_out, enabled_out);
					compare_field("at_start", want.flags.at_start, at_start);
					compare_field("at_high_limit", want.flags.at_high_limit, at_high_limit);
					compare_field("at_low_limit", want.flags.at_low_limit, at_low_limit);
					compare_field("low_warning", want.flags.low_warning, low_warning);
					compare_field("low_alarm", want.flags.low_alarm, low_alarm);
					compare_field("high_warning", want.flags.high_warning, high_warning);
					compare_field("high_alarm", want.flags.high_alarm, high_alarm);
				end
			end
			if (in_valid && in_ready) begin
				advance_count({enable, pulse, count_down, hold, load_start}, fresh);
				due_results.push_back(fresh);
			end
			outstanding = due_results.size();
		end
	end

endmodule

>>> tb/up_down_pulse_counter_with_limits_core_tb.sv
// ----------------------------------------------------------------------------
// Up/down pulse counter: testbench top
// Drives register settings and scan ticks with random gaps and back-pressure,
// then reports the verdict from the tick checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module up_down_pulse_counter_with_limits_core_tb;
	import udpc_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_OFF   = 400;
	localparam int PHASES     = 12;
	localparam int PHASE_LEN  = 118;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [VALUE_W-1:0]        cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic                      enable;
	logic                      pulse;
	logic                      count_down;
	logic                      hold;
	logic                      load_start;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [VALUE_W-1:0] count;
	logic                      enabled_out;
	logic                      at_start;
	logic                      at_high_limit;
	logic                      at_low_limit;
	logic                      low_warning;
	logic                      low_alarm;
	logic                      high_warning;
	logic                      high_alarm;
	int                        mismatches;
	int                        outstanding;

	logic [VALUE_W-1:0] plan [8];
	bit                 tx_calm;
	bit                 rx_calm;
	bit                 stall_req;
	int                 idle_cycles;

	up_down_pulse_counter_with_limits_core DUT (.*);
	udpc_tick_checker checker_i (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (cfg_valid && cfg_ready) || (in_valid && in_ready)
				|| (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic item_t tick(input bit en, input bit p, input bit dn, input bit h,
			input bit ld);
		item_t it;
		it = {en, p, dn, h, ld};
		return it;
	endfunction

	function automatic item_t random_tick(input bit dir, input bit last_pulse);
		item_t it;
		if ($urandom_range(0, 9) == 0)
			return item_t'(5'($urandom_range(0, 31)));
		it.enable     = ($urandom_range(0, 11) != 0);
		it.pulse      = ($urandom_range(0, 3) == 0) ? last_pulse : ~last_pulse;
		it.count_down = ($urandom_range(0, 7) == 0) ? ~dir : dir;
		it.hold       = ($urandom_range(0, 9) == 0);
		it.load_start = ($urandom_range(0, 47) == 0);
		return it;
	endfunction

	task automatic write_setting(input cfg_idx_t idx, input logic [VALUE_W-1:0] d);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data  <= d;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_plan();
		for (int i = 0; i < 8; i++)
			write_setting(cfg_idx_t'(i), plan[i]);
	endtask

	task automatic offer_tick(input item_t it);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		{enable, pulse, count_down, hold, load_start} <= it;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	// drain every pending result before touching the registers
	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic random_plan();
		int unit;
		int base;
		case ($urandom_range(0, 3))
			0: foreach (plan[i]) plan[i] = $urandom();
			1: foreach (plan[i])
				case ($urandom_range(0, 4))
					0: plan[i] = VAL_MAX;
					1: plan[i] = VAL_MIN;
					2: plan[i] = '0;
					3: plan[i] = '1;
					default: plan[i] = $urandom();
				endcase
			default: begin
				unit = $urandom_range(1, 1023);
				base = (int'($urandom_range(0, 4095)) - 2048) * 256;
				plan[CFG_START_VALUE]      = base;
				plan[CFG_STEP_SIZE]        = $urandom_range(0, 1) ? -unit : unit;
				plan[CFG_HIGH_LIMIT]       = base + 12 * unit;
				plan[CFG_LOW_LIMIT]        = base - 12 * unit;
				plan[CFG_LOW_ALARM_LEVEL]  = base - 7 * unit;
				plan[CFG_HIGH_ALARM_LEVEL] = base + 7 * unit;
				plan[CFG_LOW_WARN_MARGIN]  = 3 * unit;
				plan[CFG_HIGH_WARN_MARGIN] = 3 * unit;
				if ($urandom_range(0, 7) == 0) begin
					plan[CFG_HIGH_LIMIT] = base - 12 * unit;
					plan[CFG_LOW_LIMIT]  = base + 12 * unit;
				end
			end
		endcase
		write_plan();
	endtask

	initial begin : drain
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_req) begin
				stall_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_OFF) @(negedge clk);
			end else begin
				if ($urandom_range(0, 39) == 0)
					rx_calm = ~rx_calm;
				gap = rx_calm ? 0 : $urandom_range(0, 15);
				if (gap > 0) begin
					out_ready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : stimulus
		item_t nxt;
		bit    sweep_down;
		bit    last_pulse;
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		in_valid   = 1'b0;
		enable     = 1'b0;
		pulse      = 1'b0;
		count_down = 1'b0;
		hold       = 1'b0;
		load_start = 1'b0;
		tx_calm    = 1'b0;
		rx_calm    = 1'b0;
		stall_req  = 1'b0;
		sweep_down = 1'b0;
		last_pulse = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// small bands around the start value
		plan[CFG_START_VALUE]      = 32'(10 * 256);
		plan[CFG_STEP_SIZE]        = 32'(256);
		plan[CFG_HIGH_LIMIT]       = 32'(11 * 256);
		plan[CFG_LOW_LIMIT]        = 32'(9 * 256);
		plan[CFG_LOW_ALARM_LEVEL]  = 32'(10 * 256);
		plan[CFG_HIGH_ALARM_LEVEL] = 32'(10 * 256);
		plan[CFG_LOW_WARN_MARGIN]  = 32'(256);
		plan[CFG_HIGH_WARN_MARGIN] = '0;
		write_plan();
		offer_tick(tick(0, 0, 0, 0, 0));
		offer_tick(tick(1, 1, 0, 0, 0));
		offer_tick(tick(1, 1, 0, 0, 0));
		offer_tick(tick(1, 0, 0, 0, 1));
		offer_tick(tick(1, 0, 1, 0, 0));
		offer_tick(tick(1, 1, 1, 1, 0));
		offer_tick(tick(1, 0, 1, 0, 0));
		offer_tick(tick(1, 1, 1, 0, 0));
		offer_tick(tick(0, 0, 0, 0, 0));
		offer_tick(tick(0, 1, 0, 0, 0));
		offer_tick(tick(1, 1, 0, 0, 0));
		offer_tick(tick(1, 0, 0, 0, 0));
		offer_tick(tick(1, 1, 0, 0, 1));

		// extremes: widest step, thresholds that overflow the value width
		wait_quiet();
		plan[CFG_START_VALUE]      = VAL_MAX;
		plan[CFG_STEP_SIZE]        = VAL_MAX;
		plan[CFG_HIGH_LIMIT]       = VAL_MAX;
		plan[CFG_LOW_LIMIT]        = VAL_MIN;
		plan[CFG_LOW_ALARM_LEVEL]  = VAL_MAX;
		plan[CFG_HIGH_ALARM_LEVEL] = VAL_MIN;
		plan[CFG_LOW_WARN_MARGIN]  = VAL_MAX;
		plan[CFG_HIGH_WARN_MARGIN] = VAL_MAX;
		write_plan();
		offer_tick(tick(1, 0, 0, 0, 1));
		offer_tick(tick(1, 1, 0, 0, 0));
		offer_tick(tick(1, 0, 1, 0, 0));
		offer_tick(tick(1, 1, 1, 0, 0));
		offer_tick(tick(1, 0, 1, 0, 0));
		offer_tick(tick(1, 1, 1, 0, 0));

		// crossed limits, most negative step
		wait_quiet();
		plan[CFG_START_VALUE]      = '0;
		plan[CFG_STEP_SIZE]        = VAL_MIN;
		plan[CFG_HIGH_LIMIT]       = -32'sd256;
		plan[CFG_LOW_LIMIT]        = 32'(256);
		plan[CFG_LOW_ALARM_LEVEL]  = VAL_MIN;
		plan[CFG_HIGH_ALARM_LEVEL] = VAL_MIN;
		plan[CFG_LOW_WARN_MARGIN]  = VAL_MIN;
		plan[CFG_HIGH_WARN_MARGIN] = VAL_MAX;
		write_plan();
		offer_tick(tick(1, 0, 0, 0, 1));
		offer_tick(tick(1, 1, 0, 0, 0));
		offer_tick(tick(1, 0, 1, 0, 0));
		offer_tick(tick(1, 1, 1, 0, 0));
		offer_tick(tick(1, 1, 0, 0, 0));

		for (int p = 0; p < PHASES; p++) begin
			wait_quiet();
			random_plan();
			tx_calm = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < PHASE_LEN; n++) begin
				if ($urandom_range(0, 29) == 0)
					sweep_down = ~sweep_down;
				if ($urandom_range(0, 39) == 0)
					tx_calm = ~tx_calm;
				if (p == 1 && n == 30)
					stall_req = 1'b1;
				nxt = random_tick(sweep_down, last_pulse);
				last_pulse = nxt.pulse;
				offer_tick(nxt);
			end
		end

		in_valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/udpc_pkg.sv
rtl/core/udpc_cfg.sv
rtl/core/udpc_step.sv
rtl/core/up_down_pulse_counter_with_limits_core.sv
tb/udpc_tick_checker.sv
tb/up_down_pulse_counter_with_limits_core_tb.sv
